// ===== hw/rtl/ppr_pkg.sv =====
// Shared constants, codes and tables for the plane point rotator.
package ppr_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int ANGLE_WIDTH       = 16;
  localparam int GUARD_BITS        = 8;

  // Angle units are 1/64 degree.
  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
  localparam logic signed [16:0] EIGHTH_TURN  = 17'sd2880;

  localparam longint GAIN_INF  = 64'd652032874;
  localparam longint GAIN_CORR = 64'd434688582;

  typedef enum logic [1:0] {
    PLANE_XY   = 2'd0,
    PLANE_YZ   = 2'd1,
    PLANE_ZX   = 2'd2,
    PLANE_NONE = 2'd3
  } plane_sel_t;

  // Q30 compensation for the CORDIC gain of n stages.
  function automatic longint gain_q30(input int n);
    longint g;
    g = GAIN_INF;
    if (2 * n < 31) begin
      g = g + (GAIN_CORR >> (2 * n));
    end
    return g;
  endfunction

  // atan(2^-i) in units of 2^-22 degree.
  function automatic int atan_q22(input int i);
    int v;
    case (i)
      0:  v = 188743680;
      1:  v = 111421900;
      2:  v = 58872272;
      3:  v = 29884485;
      4:  v = 15000234;
      5:  v = 7507429;
      6:  v = 3754631;
      7:  v = 1877430;
      8:  v = 938729;
      9:  v = 469366;
      10: v = 234683;
      11: v = 117342;
      12: v = 58671;
      13: v = 29335;
      14: v = 14668;
      15: v = 7334;
      16: v = 3667;
      17: v = 1833;
      18: v = 917;
      19: v = 458;
      20: v = 229;
      21: v = 115;
      22: v = 57;
      23: v = 29;
      24: v = 14;
      25: v = 7;
      26: v = 4;
      27: v = 2;
      28: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/ppr_if.sv =====
// Request and result channel interfaces of the plane point rotator.
interface ppr_in_if #(
  parameter int CoordWidth = ppr_pkg::COORD_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [CoordWidth-1:0]        point_x;
  logic signed [CoordWidth-1:0]        point_y;
  logic signed [CoordWidth-1:0]        point_z;
  logic signed [CoordWidth-1:0]        center_x;
  logic signed [CoordWidth-1:0]        center_y;
  logic signed [CoordWidth-1:0]        center_z;
  logic signed [ppr_pkg::ANGLE_WIDTH-1:0] angle;
  logic [1:0]                          plane_select;

  modport source (
    output valid, point_x, point_y, point_z, center_x, center_y, center_z,
           angle, plane_select,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, center_x, center_y, center_z,
           angle, plane_select,
    output ready
  );
endinterface

interface ppr_out_if #(
  parameter int CoordWidth = ppr_pkg::COORD_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] out_x;
  logic signed [CoordWidth-1:0] out_y;
  logic signed [CoordWidth-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== hw/rtl/plane_point_rotator_unit.sv =====
// Plane point rotator: pipelined CORDIC rotation of a point about a center.
//
// A request on in_ch carries a point, a center, an angle in 1/64 degree and a
// plane select (XY, YZ, ZX or no rotation). Each request yields exactly one
// result on out_ch, in request order: the point turned about the center within
// the chosen plane, saturated to the signed coordinate range.
// A request passes CORDIC_STAGES + 3 register stages before out_ch.valid rises:
// one stage for the offsets and angle reduction, one for the gain multiplier,
// one per CORDIC micro-rotation and one for rounding, re-centering and
// saturation. Throughput is one request per cycle while the receiver takes
// results; every stage holds its own valid bit.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep advancing into empty slots, so in_ch.ready only falls
// once every stage is occupied. Nothing is dropped or repeated under stalls.
// A synchronous active-low reset empties all stages; no result is pending
// afterwards and in_ch.ready is high in the first cycle after reset.
module plane_point_rotator_unit #(
  parameter int COORD_WIDTH   = ppr_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = ppr_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ppr_in_if.sink    in_ch,
  ppr_out_if.source out_ch
);
  import ppr_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int N    = CORDIC_STAGES;
  localparam int DW   = W + 1;            // center offsets
  localparam int XW   = W + GUARD_BITS + 3; // CORDIC datapath
  localparam int ZW   = 30;               // residual angle, 2^-22 degree
  localparam int RW   = 14;               // residual angle, 1/64 degree
  localparam int SW   = 5 * W + 2;        // carried point, centers, select
  localparam int NV   = N + 3;            // number of pipeline stages
  localparam int SUMW = XW - GUARD_BITS + 1;
  localparam int PW   = DW + 31;

  localparam logic signed [30:0] GAIN = 31'(gain_q30(N));
  localparam logic signed [XW-1:0] RND = XW'(1 << (GUARD_BITS - 1));
  localparam logic signed [W-1:0] SAT_HI = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] SAT_LO = {1'b1, {(W - 1){1'b0}}};

  logic [NV-1:0] v_r;
  logic [NV:0]   adv;

  logic [SW-1:0]          side_r [0:N+1];
  logic signed [DW-1:0]   da_r, db_r;
  logic [1:0]             q_r;
  logic signed [RW-1:0]   res_r;
  logic signed [XW-1:0]   x_r [0:N];
  logic signed [XW-1:0]   y_r [0:N];
  logic signed [ZW-1:0]   z_r [0:N];
  logic signed [W-1:0]    ox_r, oy_r, oz_r;

  // A stage may load when it is empty or its content moves on.
  assign adv[NV] = out_ch.ready;
  for (genvar j = 0; j < NV; j++) begin : g_adv
    assign adv[j] = !v_r[j] || adv[j+1];
  end
  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int j = 1; j < NV; j++) begin
        if (adv[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  // Stage 0: plane offsets and angle reduction into quarter turns.
  logic [SW-1:0]        side_nxt;
  logic signed [DW-1:0] da_nxt, db_nxt;
  logic [1:0]           q_nxt;
  logic signed [RW-1:0] res_nxt;

  always_comb begin
    logic signed [W-1:0]  pa, pb, ca, cb;
    logic signed [16:0]   red;
    logic signed [16:0]   res;
    pa = in_ch.point_x;
    pb = in_ch.point_y;
    ca = in_ch.center_x;
    cb = in_ch.center_y;
    case (plane_sel_t'(in_ch.plane_select))
      PLANE_YZ: begin
        pa = in_ch.point_y;  pb = in_ch.point_z;
        ca = in_ch.center_y; cb = in_ch.center_z;
      end
      PLANE_ZX: begin
        pa = in_ch.point_z;  pb = in_ch.point_x;
        ca = in_ch.center_z; cb = in_ch.center_x;
      end
      default: begin
        pa = in_ch.point_x;  pb = in_ch.point_y;
        ca = in_ch.center_x; cb = in_ch.center_y;
      end
    endcase
    da_nxt = DW'(pa) - DW'(ca);
    db_nxt = DW'(pb) - DW'(cb);

    red = 17'(in_ch.angle);
    if (red < 0) begin
      red = red + FULL_TURN;
      if (red < 0) begin
        red = red + FULL_TURN;
      end
    end else if (red >= FULL_TURN) begin
      red = red - FULL_TURN;
    end

    if (red < EIGHTH_TURN) begin
      q_nxt = 2'd0; res = red;
    end else if (red < EIGHTH_TURN + QUARTER_TURN) begin
      q_nxt = 2'd1; res = red - QUARTER_TURN;
    end else if (red < EIGHTH_TURN + 17'sd2 * QUARTER_TURN) begin
      q_nxt = 2'd2; res = red - 17'sd2 * QUARTER_TURN;
    end else if (red < FULL_TURN - EIGHTH_TURN) begin
      q_nxt = 2'd3; res = red - 17'sd3 * QUARTER_TURN;
    end else begin
      q_nxt = 2'd0; res = red - FULL_TURN;
    end
    res_nxt = RW'(res);

    side_nxt = {in_ch.plane_select, cb, ca,
                in_ch.point_z, in_ch.point_y, in_ch.point_x};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_r[0] <= side_nxt;
      da_r      <= da_nxt;
      db_r      <= db_nxt;
      q_r       <= q_nxt;
      res_r     <= res_nxt;
    end
  end

  // Stage 1: exact quarter turns, then gain compensation.
  logic signed [DW-1:0] qa, qb;
  logic signed [PW-1:0] pa_prod, pb_prod;

  always_comb begin
    case (q_r)
      2'd1: begin
        qa = -db_r; qb = da_r;
      end
      2'd2: begin
        qa = -da_r; qb = -db_r;
      end
      2'd3: begin
        qa = db_r;  qb = -da_r;
      end
      default: begin
        qa = da_r;  qb = db_r;
      end
    endcase
  end

  assign pa_prod = PW'(qa) * PW'(GAIN);
  assign pb_prod = PW'(qb) * PW'(GAIN);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side_r[1] <= side_r[0];
      x_r[0]    <= XW'($signed(pa_prod[PW-1:30-GUARD_BITS]));
      y_r[0]    <= XW'($signed(pb_prod[PW-1:30-GUARD_BITS]));
      z_r[0]    <= ZW'(res_r) <<< 16;
    end
  end

  // CORDIC micro-rotations, one per stage.
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q22(i));
    logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_comb begin
      if (!z_r[i][ZW-1]) begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - ATAN;
      end else begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i+2]) begin
        side_r[i+2] <= side_r[i+1];
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
      end
    end
  end

  // Last stage: round off guard bits, add the center back, saturate.
  function automatic logic signed [W-1:0] sat_fn(input logic signed [SUMW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SUMW'(SAT_HI)) begin
      r = SAT_HI;
    end else if (v < SUMW'(SAT_LO)) begin
      r = SAT_LO;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  logic [SW-1:0]          side_f;
  logic signed [W-1:0]    px, py, pz, fca, fcb, ra, rb;
  logic [1:0]             fsel;
  logic signed [XW-1:0]   xr, yr;
  logic signed [SUMW-1:0] sa, sb;
  logic signed [W-1:0]    ox_nxt, oy_nxt, oz_nxt;

  assign side_f = side_r[N+1];
  assign px     = side_f[W-1:0];
  assign py     = side_f[2*W-1:W];
  assign pz     = side_f[3*W-1:2*W];
  assign fca    = side_f[4*W-1:3*W];
  assign fcb    = side_f[5*W-1:4*W];
  assign fsel   = side_f[SW-1:5*W];

  assign xr = x_r[N] + RND;
  assign yr = y_r[N] + RND;
  assign sa = SUMW'($signed(xr[XW-1:GUARD_BITS])) + SUMW'(fca);
  assign sb = SUMW'($signed(yr[XW-1:GUARD_BITS])) + SUMW'(fcb);
  assign ra = sat_fn(sa);
  assign rb = sat_fn(sb);

  always_comb begin
    case (plane_sel_t'(fsel))
      PLANE_XY: begin
        ox_nxt = ra; oy_nxt = rb; oz_nxt = pz;
      end
      PLANE_YZ: begin
        ox_nxt = px; oy_nxt = ra; oz_nxt = rb;
      end
      PLANE_ZX: begin
        ox_nxt = rb; oy_nxt = py; oz_nxt = ra;
      end
      default: begin
        ox_nxt = px; oy_nxt = py; oz_nxt = pz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[NV-1]) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign out_ch.valid = v_r[NV-1];
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;

endmodule

// ===== sim/plane_point_rotator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the plane point rotator: directed rows, then random requests.
module plane_point_rotator_unit_tb;
  import ppr_pkg::*;

  localparam int COORD_W  = 32;
  localparam int STAGES   = 18;
  localparam int LATENCY  = STAGES + 3;
  localparam int RAND_PER_PHASE = 175;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
  localparam logic signed [COORD_W-1:0] ONE   = 32'sh00010000;

  // Angle units of 1/64 degree.
  localparam longint TURN_UNITS    = 64'sd23040;
  localparam longint QUARTER_UNITS = 64'sd5760;
  localparam longint EIGHTH_UNITS  = 64'sd2880;

  // Q30 gain compensation; the correction term vanishes once 2n reaches 31.
  localparam longint GAIN_Q30 = 64'sd652032874 +
                                ((2 * STAGES < 31) ? (64'sd434688582 >>> (2 * STAGES)) : 64'sd0);

  // atan(2^-i) in units of 2^-22 degree.
  localparam longint ATAN_STEP [32] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
    1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [15:0]        angle;
    plane_sel_t                sel;
  } point_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord3_t;

  typedef struct {
    point_req_t req;
    bit         known;
    coord3_t    val;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ppr_in_if  #(.CoordWidth(COORD_W)) in_ch ();
  ppr_out_if #(.CoordWidth(COORD_W)) out_ch ();

  plane_point_rotator_unit #(
    .COORD_WIDTH  (COORD_W),
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  coord3_t    expected_points [$];
  dir_row_t   directed_rows [$];
  int         src_idle_pct;
  int         sink_stall_pct;
  int         mismatch_count;
  int         results_checked;
  int         requests_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint saturate_coord(input longint v);
    if (v > longint'(C_MAX)) begin
      return longint'(C_MAX);
    end
    if (v < longint'(C_MIN)) begin
      return longint'(C_MIN);
    end
    return v;
  endfunction

  // Turns the point about the center within the selected plane.
  function automatic coord3_t rotate_point(input point_req_t r);
    longint pt [3];
    longint ct [3];
    longint rs [3];
    longint a, b, t, red, k, z, x, y, xs, ys;
    int     ia, ib;
    coord3_t o;
    pt[0] = r.px; pt[1] = r.py; pt[2] = r.pz;
    ct[0] = r.cx; ct[1] = r.cy; ct[2] = r.cz;
    for (int i = 0; i < 3; i++) begin
      rs[i] = pt[i];
    end
    if (r.sel != PLANE_NONE) begin
      ia = int'(r.sel);
      ib = (ia + 1) % 3;
      a = pt[ia] - ct[ia];
      b = pt[ib] - ct[ib];
      red = longint'(r.angle) % TURN_UNITS;
      if (red < 0) begin
        red = red + TURN_UNITS;
      end
      k = (red + EIGHTH_UNITS) / QUARTER_UNITS;
      z = (red - k * QUARTER_UNITS) * 65536;
      case (k % 4)
        1: begin
          t = a; a = -b; b = t;
        end
        2: begin
          a = -a; b = -b;
        end
        3: begin
          t = a; a = b; b = -t;
        end
        default: ;
      endcase
      x = (a * GAIN_Q30) >>> (30 - GUARD_BITS);
      y = (b * GAIN_Q30) >>> (30 - GUARD_BITS);
      for (int n = 0; n < STAGES && n < 32; n++) begin
        xs = x >>> n;
        ys = y >>> n;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - ATAN_STEP[n];
        end else begin
          x = x + ys; y = y - xs; z = z + ATAN_STEP[n];
        end
      end
      rs[ia] = saturate_coord(((x + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS) + ct[ia]);
      rs[ib] = saturate_coord(((y + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS) + ct[ib]);
    end
    o.x = rs[0][COORD_W-1:0];
    o.y = rs[1][COORD_W-1:0];
    o.z = rs[2][COORD_W-1:0];
    return o;
  endfunction

  function automatic void add_row(
    input logic signed [COORD_W-1:0] px, py, pz, cx, cy, cz,
    input logic signed [15:0] ang, input plane_sel_t sel,
    input bit known, input logic signed [COORD_W-1:0] ex, ey, ez
  );
    dir_row_t row;
    row.req = '{px: px, py: py, pz: pz, cx: cx, cy: cy, cz: cz, angle: ang, sel: sel};
    row.known = known;
    row.val = '{x: ex, y: ey, z: ez};
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly points near a center, with wide, extreme and zero offsets mixed in.
  function automatic point_req_t draw_request();
    point_req_t r;
    int         mode;
    int         amode;
    mode = $urandom_range(9);
    r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
    r.px = $urandom; r.py = $urandom; r.pz = $urandom;
    if (mode <= 5) begin
      r.cx = $signed($urandom) >>> $urandom_range(4, 20);
      r.cy = $signed($urandom) >>> $urandom_range(4, 20);
      r.cz = $signed($urandom) >>> $urandom_range(4, 20);
      r.px = r.cx + ($signed($urandom) >>> $urandom_range(6, 24));
      r.py = r.cy + ($signed($urandom) >>> $urandom_range(6, 24));
      r.pz = r.cz + ($signed($urandom) >>> $urandom_range(6, 24));
    end else if (mode == 8) begin
      r.px = pick_extreme(); r.py = pick_extreme(); r.pz = pick_extreme();
      r.cx = pick_extreme(); r.cy = pick_extreme(); r.cz = pick_extreme();
    end else if (mode == 9) begin
      r.px = r.cx; r.py = r.cy; r.pz = r.cz;
    end
    amode = $urandom_range(9);
    if (amode < 8) begin
      r.angle = 16'(int'($urandom_range(46080)) - 23040);
    end else if (amode == 8) begin
      r.angle = 16'($urandom);
    end else begin
      // Near the quarter-turn split points, where the residual wraps.
      r.angle = 16'(2880 * int'($urandom_range(16)) - 23040 + int'($urandom_range(2)) - 1);
    end
    r.sel = plane_sel_t'(2'($urandom_range(3)));
    return r;
  endfunction

  task automatic send_request(input point_req_t r, input bit known, input coord3_t known_val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.point_x      <= r.px;
    in_ch.point_y      <= r.py;
    in_ch.point_z      <= r.pz;
    in_ch.center_x     <= r.cx;
    in_ch.center_y     <= r.cy;
    in_ch.center_z     <= r.cz;
    in_ch.angle        <= r.angle;
    in_ch.plane_select <= r.sel;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_points.push_back(known ? known_val : rotate_point(r));
    requests_sent++;
  endtask

  always @(posedge clk) begin : result_check
    coord3_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", out_ch.out_x, out_ch.out_y, out_ch.out_z);
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        results_checked++;
        if (out_ch.out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_ch.out_x);
          mismatch_count++;
        end
        if (out_ch.out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_ch.out_y);
          mismatch_count++;
        end
        if (out_ch.out_z !== want.z) begin
          $error("out_z: expected %0d, got %0d", want.z, out_ch.out_z);
          mismatch_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.point_x      = '0;
    in_ch.point_y      = '0;
    in_ch.point_z      = '0;
    in_ch.center_x     = '0;
    in_ch.center_y     = '0;
    in_ch.center_z     = '0;
    in_ch.angle        = '0;
    in_ch.plane_select = PLANE_XY;
    out_ch.ready       = 1'b0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    mismatch_count     = 0;
    results_checked    = 0;
    requests_sent      = 0;

    // Rows with a typed result: pass-through, zero offset and full saturation.
    add_row(C_MAX, C_MIN, 32'sh12345678, 5, 6, 7, 1000, PLANE_NONE,
            1, C_MAX, C_MIN, 32'sh12345678);
    add_row(C_MIN, C_MAX, -1, C_MAX, C_MIN, 0, -32768, PLANE_NONE, 1, C_MIN, C_MAX, -1);
    add_row(123456, -654321, 777, 123456, -654321, 777, 4000, PLANE_XY,
            1, 123456, -654321, 777);
    add_row(C_MAX, C_MIN, -1, C_MAX, C_MIN, -1, 32767, PLANE_YZ, 1, C_MAX, C_MIN, -1);
    add_row(-9, C_MAX, C_MIN, -9, C_MAX, C_MIN, -32768, PLANE_ZX, 1, -9, C_MAX, C_MIN);
    add_row(C_MAX, C_MAX, 5, C_MIN, C_MIN, 5, 11520, PLANE_XY, 1, C_MIN, C_MIN, 5);
    add_row(42, C_MIN, C_MIN, 0, C_MAX, C_MAX, 11520, PLANE_YZ, 1, 42, C_MAX, C_MAX);
    add_row(C_MAX, 7, C_MAX, C_MIN, 7, C_MIN, -11520, PLANE_ZX, 1, C_MIN, 7, C_MIN);
    // Angle boundaries and every plane, checked by the predictor.
    add_row(ONE, 0, 0, 0, 0, 0, 0, PLANE_XY, 0, 0, 0, 0);
    add_row(ONE, 0, 0, 0, 0, 0, 5760, PLANE_XY, 0, 0, 0, 0);
    add_row(0, ONE, ONE * 2, 0, 0, 0, 2880, PLANE_YZ, 0, 0, 0, 0);
    add_row(ONE, 0, ONE, 0, 0, 0, -2880, PLANE_ZX, 0, 0, 0, 0);
    add_row(ONE, ONE, 0, 0, 0, 0, 2879, PLANE_XY, 0, 0, 0, 0);
    add_row(ONE, ONE, 0, 0, 0, 0, -2881, PLANE_XY, 0, 0, 0, 0);
    add_row(-ONE * 3, ONE * 5, 0, ONE, -ONE, 0, 23040, PLANE_XY, 0, 0, 0, 0);
    add_row(0, -ONE * 3, ONE * 5, 0, ONE, -ONE, -23040, PLANE_YZ, 0, 0, 0, 0);
    add_row(ONE * 100, -ONE * 50, ONE * 7, ONE * 10, ONE * 20, -ONE * 30, 32767, PLANE_ZX,
            0, 0, 0, 0);
    add_row(ONE * 100, -ONE * 50, ONE * 7, ONE * 10, ONE * 20, -ONE * 30, -32768, PLANE_XY,
            0, 0, 0, 0);
    add_row(C_MAX, 0, 0, 0, 0, 0, 8640, PLANE_XY, 0, 0, 0, 0);
    add_row(C_MIN, C_MIN, C_MIN, 0, 0, 0, 17280, PLANE_YZ, 0, 0, 0, 0);
    add_row(0, C_MAX, C_MIN, C_MAX, 0, 0, 20160, PLANE_ZX, 0, 0, 0, 0);
    add_row(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1, PLANE_XY, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].val);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;  sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 88; sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;  sink_stall_pct = 88;
        end
        default: begin
          src_idle_pct = 14; sink_stall_pct = 14;
        end
      endcase
      repeat (RAND_PER_PHASE) send_request(draw_request(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * LATENCY) @(posedge clk);

    $display("Sent %0d requests (%0d directed) through four handshake phases.",
             requests_sent, directed_rows.size());
    $display("Compared %0d rotated points field by field; %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
